// ----- design/uer_pkg.sv -----
// Shared types and constants for the ultrasonic echo ranger.
package uer_pkg;

  localparam int unsigned NUM_CFG = 3;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DIST = 2'd2;

  // Reset values of the registers.
  localparam logic [7:0] TRIGGER_RST = 8'd10;
  localparam logic [15:0] TIMEOUT_RST = 16'd3700;
  localparam logic [7:0] MAX_DIST_RST = 8'd99;

  // Request codes.
  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_START = 1'b1;

  // Distance = floor((ticks * 343 + 10000) / 20000), tracked incrementally.
  localparam int unsigned ACC_W = 15;
  localparam logic [ACC_W-1:0] DIST_STEP = 15'd343;
  localparam logic [ACC_W-1:0] DIST_DIV = 15'd20000;
  localparam logic [ACC_W-1:0] DIST_BIAS = 15'd10000;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_TRIG = 4'b0010,
    PH_WAIT = 4'b0100,
    PH_MEAS = 4'b1000
  } phase_e;

  // One classified item as it sits in the queue.
  typedef struct packed {
    logic       is_start;
    logic [2:0] echo;
  } item_t;

  // Queue head as seen by the back end.
  typedef struct packed {
    logic  valid;
    item_t item;
  } head_t;

endpackage

// ----- design/ultrasonic_echo_ranger.sv -----
// Top level of the ultrasonic echo ranger.
// The ranger takes one item per clock unless the output stalls: each tick or start
// transaction yields exactly one result transaction, held in the output register. Items
// pass through a two-entry queue into the sequencer, which updates its state and the
// registered result once per item; the echo-to-distance conversion is done incrementally
// with one add and compare per tick, sustaining one item per cycle when not stalled.
// Configuration writes are always accepted and should be made while the block is idle.
module ultrasonic_echo_ranger import uer_pkg::*; #(
  parameter int unsigned NUM_SENSORS = 3,
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  req_type_i,
  input  logic [2:0]            echo_levels_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [2:0]            trigger_lines_o,
  output logic                  busy_res_o,
  output logic                  sweep_done_o,
  output logic                  timed_out_o,
  output logic [23:0]           packed_distances_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  head_t head;
  logic  pop;

  assign cfg_ready_o = 1'b1;

  uer_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .req_type_i    (req_type_i),
    .echo_levels_i (echo_levels_i),
    .head_o        (head),
    .pop_i         (pop)
  );

  uer_back #(
    .NUM_SENSORS (NUM_SENSORS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .head_i             (head),
    .pop_o              (pop),
    .cfg_valid_i        (cfg_valid_i && cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .trigger_lines_o    (trigger_lines_o),
    .busy_res_o         (busy_res_o),
    .sweep_done_o       (sweep_done_o),
    .timed_out_o        (timed_out_o),
    .packed_distances_o (packed_distances_o)
  );

endmodule

// ----- design/uer_front.sv -----
// Front end: accepts items, classifies them and holds them in a two-entry queue.
module uer_front import uer_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       req_type_i,
  input  logic [2:0] echo_levels_i,
  output head_t      head_o,
  input  logic       pop_i
);

  item_t      slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] fill_q, fill_d;
  logic       push;
  item_t      new_item;

  assign in_stall_o = (fill_q == 2'd2);
  assign push = in_valid_i && !in_stall_o;

  always_comb begin
    new_item.is_start = (req_type_i == REQ_START);
    new_item.echo = echo_levels_i;
  end

  assign head_o.valid = (fill_q != 2'd0);
  assign head_o.item = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d = fill_q;
    if (push) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    if (push && !pop_i) begin
      fill_d = fill_q + 2'd1;
    end else if (!push && pop_i) begin
      fill_d = fill_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= new_item;
    end
  end

endmodule

// ----- design/uer_back.sv -----
// Back end: ranging sequencer, configuration registers and output register.
module uer_back import uer_pkg::*; #(
  parameter int unsigned NUM_SENSORS = 3,
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  head_t                 head_i,
  output logic                  pop_o,
  input  logic                  cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [2:0]            trigger_lines_o,
  output logic                  busy_res_o,
  output logic                  sweep_done_o,
  output logic                  timed_out_o,
  output logic [23:0]           packed_distances_o
);

  // The counter also times the trigger and the echo timeout, so it is never under 16 bits.
  localparam int unsigned CNT_W = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
  localparam logic [CNT_W-1:0] CNT_SAT = CNT_W'({COUNT_WIDTH{1'b1}});
  localparam logic [1:0] LAST_SENSOR = 2'(NUM_SENSORS - 1);

  logic [7:0]       trig_cfg_q;
  logic [15:0]      tout_cfg_q;
  logic [7:0]       max_cfg_q;

  phase_e           phase_q, phase_d;
  logic [1:0]       sensor_q, sensor_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [ACC_W-1:0] acc_q, acc_d;
  logic [7:0]       quot_q, quot_d;
  logic [2:0][7:0]  dist_q, dist_d;
  logic [23:0]      packed_q, packed_d;

  logic             out_valid_q, out_valid_d;
  logic [2:0]       trig_out_q, trig_out_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic             tout_q, tout_d;

  logic             level;
  logic [CNT_W-1:0] cnt_inc;
  logic [ACC_W-1:0] acc_inc;
  logic [7:0]       dist_clamped;

  assign pop_o = head_i.valid && (!out_valid_q || !out_stall_i);
  assign level = head_i.item.echo[sensor_q];
  assign cnt_inc = cnt_q + CNT_W'(1);
  assign acc_inc = acc_q + DIST_STEP;
  assign dist_clamped = (quot_q > max_cfg_q) ? max_cfg_q : quot_q;

  always_comb begin
    phase_d = phase_q;
    sensor_d = sensor_q;
    cnt_d = cnt_q;
    acc_d = acc_q;
    quot_d = quot_q;
    dist_d = dist_q;
    packed_d = packed_q;
    done_d = 1'b0;
    tout_d = 1'b0;
    if (head_i.item.is_start) begin
      if (phase_q == PH_IDLE) begin
        phase_d = PH_TRIG;
        sensor_d = 2'd0;
        cnt_d = '0;
      end
    end else begin
      case (phase_q)
        PH_IDLE: begin
        end
        PH_TRIG: begin
          cnt_d = cnt_inc;
          if (cnt_inc >= CNT_W'(trig_cfg_q)) begin
            phase_d = PH_WAIT;
            cnt_d = '0;
          end
        end
        PH_WAIT: begin
          if (level) begin
            phase_d = PH_MEAS;
            cnt_d = CNT_W'(1);
            // Distance accumulator after the first high tick.
            acc_d = DIST_BIAS + DIST_STEP;
            quot_d = 8'd0;
          end else if (cnt_q >= CNT_W'(tout_cfg_q)) begin
            phase_d = PH_IDLE;
            cnt_d = '0;
            sensor_d = 2'd0;
            tout_d = 1'b1;
          end else begin
            cnt_d = cnt_inc;
          end
        end
        PH_MEAS: begin
          if (level) begin
            if (cnt_q < CNT_SAT) begin
              cnt_d = cnt_inc;
              if (acc_inc >= DIST_DIV) begin
                acc_d = acc_inc - DIST_DIV;
                if (quot_q != 8'hff) begin
                  quot_d = quot_q + 8'd1;
                end
              end else begin
                acc_d = acc_inc;
              end
            end
          end else begin
            dist_d[sensor_q] = dist_clamped;
            cnt_d = '0;
            if (sensor_q == LAST_SENSOR) begin
              packed_d = {dist_d[2], dist_d[1], dist_d[0]};
              phase_d = PH_IDLE;
              sensor_d = 2'd0;
              done_d = 1'b1;
            end else begin
              sensor_d = sensor_q + 2'd1;
              phase_d = PH_TRIG;
            end
          end
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    trig_out_d = (phase_d == PH_TRIG) ? (3'b001 << sensor_d) : 3'b000;
    busy_d = (phase_d != PH_IDLE);
    out_valid_d = pop_o ? 1'b1 : (out_stall_i && out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trig_cfg_q <= TRIGGER_RST;
      tout_cfg_q <= TIMEOUT_RST;
      max_cfg_q <= MAX_DIST_RST;
      phase_q <= PH_IDLE;
      sensor_q <= 2'd0;
      cnt_q <= '0;
      acc_q <= '0;
      quot_q <= 8'd0;
      dist_q <= '0;
      packed_q <= 24'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_TRIGGER: trig_cfg_q <= cfg_data_i[7:0];
          CFG_TIMEOUT: tout_cfg_q <= cfg_data_i;
          CFG_MAX_DIST: max_cfg_q <= cfg_data_i[7:0];
          default: begin
          end
        endcase
      end
      if (pop_o) begin
        phase_q <= phase_d;
        sensor_q <= sensor_d;
        cnt_q <= cnt_d;
        acc_q <= acc_d;
        quot_q <= quot_d;
        dist_q <= dist_d;
        packed_q <= packed_d;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      trig_out_q <= trig_out_d;
      busy_q <= busy_d;
      done_q <= done_d;
      tout_q <= tout_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign trigger_lines_o = trig_out_q;
  assign busy_res_o = busy_q;
  assign sweep_done_o = done_q;
  assign timed_out_o = tout_q;
  assign packed_distances_o = packed_q;

endmodule

// ----- design/uer_checker.sv -----
// Port-level checker for the ultrasonic echo ranger and its bind statement.
module uer_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [2:0]  trigger_lines_o,
  input logic        busy_res_o,
  input logic        sweep_done_o,
  input logic        timed_out_o,
  input logic [23:0] packed_distances_o
);

  // A stalled result transaction holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(packed_distances_o) &&
      $stable(trigger_lines_o) && $stable(busy_res_o) && $stable(sweep_done_o) &&
      $stable(timed_out_o))
    else $error("stalled result changed");

  a_done_xor_tout: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(sweep_done_o && timed_out_o))
    else $error("sweep done and timeout on the same result");

  a_one_trigger: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot0(trigger_lines_o))
    else $error("more than one trigger line driven");

  // A finished or aborted sweep leaves the block idle with all triggers low.
  a_end_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (sweep_done_o || timed_out_o) |-> !busy_res_o && (trigger_lines_o == 3'b000))
    else $error("busy after sweep end");

  a_trig_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (trigger_lines_o != 3'b000) |-> busy_res_o)
    else $error("trigger driven while idle");

endmodule

bind ultrasonic_echo_ranger uer_checker u_uer_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .out_valid_o        (out_valid_o),
  .out_stall_i        (out_stall_i),
  .trigger_lines_o    (trigger_lines_o),
  .busy_res_o         (busy_res_o),
  .sweep_done_o       (sweep_done_o),
  .timed_out_o        (timed_out_o),
  .packed_distances_o (packed_distances_o)
);
